@@ rtl/x86ea_pkg.sv @@
// ----------------------------------------------------------------------------
// x86ea_pkg
// Shared types, codes and helpers for the ModR/M effective-address block.
// ----------------------------------------------------------------------------
package x86ea_pkg;

	// item kinds on the input stream
	typedef enum logic {
		OP_EA     = 1'b0,
		OP_REG_WR = 1'b1
	} op_t;

	// ModR/M mod field
	localparam logic [1:0] MOD_IND = 2'd0;
	localparam logic [1:0] MOD_D8  = 2'd1;
	localparam logic [1:0] MOD_D32 = 2'd2;
	localparam logic [1:0] MOD_REG = 2'd3;

	// 32-bit rm / SIB codes
	localparam logic [2:0] RM_SIB  = 3'd4;
	localparam logic [2:0] RM_DISP = 3'd5;
	localparam logic [2:0] REG_ESP = 3'd4;
	localparam logic [2:0] REG_EBP = 3'd5;
	localparam logic [2:0] IDX_NONE = 3'd4;

	// 16-bit rm codes
	localparam logic [2:0] RM16_BX_SI = 3'd0;
	localparam logic [2:0] RM16_BX_DI = 3'd1;
	localparam logic [2:0] RM16_BP_SI = 3'd2;
	localparam logic [2:0] RM16_BP_DI = 3'd3;
	localparam logic [2:0] RM16_SI    = 3'd4;
	localparam logic [2:0] RM16_DI    = 3'd5;
	localparam logic [2:0] RM16_BP    = 3'd6;
	localparam logic [2:0] RM16_BX    = 3'd7;

	// register numbers used by 16-bit forms
	localparam logic [2:0] REG_BX = 3'd3;
	localparam logic [2:0] REG_BP = 3'd5;
	localparam logic [2:0] REG_SI = 3'd6;
	localparam logic [2:0] REG_DI = 3'd7;

	localparam int unsigned NUM_GPR = 8;
	localparam logic [15:0] ADDR16_MASK = 16'hFFFF;

	typedef logic [31:0] gpr_t;

	// register file read selection
	typedef struct packed {
		logic [2:0] a_idx;
		logic [2:0] b_idx;
		logic       b_en;
	} rd_sel_t;

	// decode fields handed to the address adder stage
	typedef struct packed {
		logic        a32;
		logic [7:0]  modrm;
		logic [39:0] tb;
		logic        seg_ovr;
		logic        b_en;
	} agu_ctl_t;

	typedef struct packed {
		logic [31:0] ea;
		logic        ss;
		logic        is_reg;
		logic [2:0]  len;
	} agu_res_t;

	// Picks the two register file ports: A = base (or first of a 16-bit pair),
	// B = index (or second of the pair).
	function automatic rd_sel_t rd_select(input logic a32, input logic [7:0] modrm,
		input logic [7:0] sib);
		rd_sel_t    s;
		logic [2:0] rm;
		rm = modrm[2:0];
		s  = '0;
		if (a32) begin
			s.a_idx = (rm == RM_SIB) ? sib[2:0] : rm;
			s.b_idx = sib[5:3];
			s.b_en  = (rm == RM_SIB) && (sib[5:3] != IDX_NONE);
		end else begin
			case (rm)
				RM16_BX_SI, RM16_BX_DI, RM16_BX: s.a_idx = REG_BX;
				RM16_BP_SI, RM16_BP_DI, RM16_BP: s.a_idx = REG_BP;
				RM16_SI:                         s.a_idx = REG_SI;
				default:                         s.a_idx = REG_DI;
			endcase
			s.b_idx = (rm == RM16_BX_DI || rm == RM16_BP_DI) ? REG_DI : REG_SI;
			s.b_en  = (rm == RM16_BX_SI || rm == RM16_BX_DI ||
				rm == RM16_BP_SI || rm == RM16_BP_DI);
		end
		return s;
	endfunction

endpackage

@@ rtl/x86ea_agu.sv @@
// ----------------------------------------------------------------------------
// x86ea_agu
// Effective-address adder: base + scaled index + displacement, segment and
// length flags, from register operands already read.
// ----------------------------------------------------------------------------
module x86ea_agu (
	input  x86ea_pkg::agu_ctl_t ctl,
	input  x86ea_pkg::gpr_t     opa,
	input  x86ea_pkg::gpr_t     opb,
	output x86ea_pkg::agu_res_t res
);

	logic [1:0]  mode;
	logic [2:0]  rm;
	logic [2:0]  base;
	logic [1:0]  scale;
	logic        sib_form;
	logic [7:0]  d8;
	logic [31:0] d32;
	logic [31:0] base_t;
	logic [31:0] idx_t;
	logic [31:0] disp_t;
	logic [31:0] sum;
	logic [2:0]  len;
	logic        ss;

	always_comb begin
		mode     = ctl.modrm[7:6];
		rm       = ctl.modrm[2:0];
		base     = ctl.tb[2:0];
		scale    = ctl.tb[7:6];
		sib_form = ctl.a32 && (rm == x86ea_pkg::RM_SIB);
		// displacement starts after SIB when there is one
		d8       = sib_form ? ctl.tb[15:8] : ctl.tb[7:0];
		d32      = sib_form ? ctl.tb[39:8] : ctl.tb[31:0];
		base_t   = opa;
		idx_t    = '0;
		disp_t   = '0;
		len      = '0;
		ss       = 1'b0;

		if (ctl.a32) begin
			if (sib_form) begin
				len = 3'd1;
				if (mode == x86ea_pkg::MOD_IND && base == x86ea_pkg::REG_EBP) begin
					base_t = ctl.tb[39:8];
					len    = 3'd5;
				end else begin
					ss = (base == x86ea_pkg::REG_ESP) || (base == x86ea_pkg::REG_EBP);
				end
				if (ctl.b_en)
					idx_t = opb << scale;
			end else if (mode == x86ea_pkg::MOD_IND && rm == x86ea_pkg::RM_DISP) begin
				base_t = ctl.tb[31:0];
				len    = 3'd4;
			end else begin
				ss = (rm == x86ea_pkg::REG_EBP);
			end
			case (mode)
				x86ea_pkg::MOD_D8: begin
					disp_t = {{24{d8[7]}}, d8};
					len    = len + 3'd1;
				end
				x86ea_pkg::MOD_D32: begin
					disp_t = d32;
					len    = len + 3'd4;
				end
				default: ;
			endcase
		end else begin
			if (mode == x86ea_pkg::MOD_IND && rm == x86ea_pkg::RM16_BP) begin
				// direct disp16
				base_t = {16'd0, ctl.tb[15:0]};
				len    = 3'd2;
			end else begin
				if (ctl.b_en)
					idx_t = opb;
				ss = rm inside {x86ea_pkg::RM16_BP_SI, x86ea_pkg::RM16_BP_DI,
					x86ea_pkg::RM16_BP};
				case (mode)
					x86ea_pkg::MOD_D8: begin
						disp_t = {{24{ctl.tb[7]}}, ctl.tb[7:0]};
						len    = 3'd1;
					end
					x86ea_pkg::MOD_D32: begin
						disp_t = {16'd0, ctl.tb[15:0]};
						len    = 3'd2;
					end
					default: ;
				endcase
			end
		end

		sum = base_t + idx_t + disp_t;

		res.ea     = ctl.a32 ? sum : {16'd0, sum[15:0] & x86ea_pkg::ADDR16_MASK};
		res.ss     = ss && !ctl.seg_ovr;
		res.is_reg = 1'b0;
		res.len    = len;
		if (mode == x86ea_pkg::MOD_REG) begin
			res.ea     = '0;
			res.ss     = 1'b0;
			res.is_reg = 1'b1;
			res.len    = '0;
		end
	end

endmodule

@@ rtl/x86_modrm_effective_address.sv @@
// ----------------------------------------------------------------------------
// x86_modrm_effective_address
// x86 ModR/M + SIB effective-address generator with its own copy of the
// eight general registers.
// ----------------------------------------------------------------------------
//
//  Channel | Dir | Signals                    | Content
//  --------+-----+----------------------------+----------------------------------
//  s_*     | in  | tvalid tready tdata tuser  | register write or decode item
//  m_*     | out | tvalid tready tdata tuser  | effective address + flags
//
//  Throughput is one item per clock while no decode is held back. A decode
//  result passes through the input register, register file read and address
//  adder, and output register.
//  Register writes update the file as they leave the input register and
//  produce no result; a decode accepted in the next cycle sees the new value.
//  Reset clears all eight registers and both stages. A decode holds in the
//  input register while the output register is full and m_tready is low, so
//  s_tready drops only then; a register write never waits.
// ----------------------------------------------------------------------------
module x86_modrm_effective_address (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	// [2:0] reg_index, [34:3] reg_value, [35] address_32, [43:36] modrm,
	// [83:44] trailing_bytes, [84] segment_override, [87:85] zero
	input  logic [87:0] s_tdata,
	// [0] operation (0 compute address, 1 write register)
	input  logic        s_tuser,
	output logic        m_tvalid,
	input  logic        m_tready,
	// [31:0] effective_address, [32] uses_stack_segment,
	// [35:33] bytes_after_modrm, [39:36] zero
	output logic [39:0] m_tdata,
	// [0] is_register_operand
	output logic        m_tuser
);

	// ---- stage 1: input register ----
	logic                  valid_s1;
	x86ea_pkg::op_t        op_s1;
	logic [2:0]            idx_s1;
	x86ea_pkg::gpr_t       val_s1;
	x86ea_pkg::agu_ctl_t   ctl_s1;

	// ---- stage 2: output register ----
	logic                  valid_s2;
	x86ea_pkg::agu_res_t   res_s2;

	x86ea_pkg::gpr_t       gpr_q [x86ea_pkg::NUM_GPR];
	x86ea_pkg::rd_sel_t    sel;
	x86ea_pkg::agu_ctl_t   agu_ctl;
	x86ea_pkg::gpr_t       opa;
	x86ea_pkg::gpr_t       opb;
	x86ea_pkg::agu_res_t   agu_res;

	logic en1, en2;
	logic wr_go;

	// stage enables, from the output side back
	assign en2 = !valid_s2 || m_tready;
	// a register write never needs the output register
	assign en1 = !valid_s1 || (op_s1 == x86ea_pkg::OP_REG_WR) || en2;
	assign s_tready = en1;

	assign wr_go = valid_s1 && (op_s1 == x86ea_pkg::OP_REG_WR);

	// stage 1
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			op_s1    <= x86ea_pkg::OP_EA;
		end else if (en1) begin
			valid_s1 <= s_tvalid;
			op_s1    <= x86ea_pkg::op_t'(s_tuser);
		end
	end

	always_ff @(posedge clk) begin
		if (en1 && s_tvalid) begin
			idx_s1          <= s_tdata[2:0];
			val_s1          <= s_tdata[34:3];
			ctl_s1.a32      <= s_tdata[35];
			ctl_s1.modrm    <= s_tdata[43:36];
			ctl_s1.tb       <= s_tdata[83:44];
			ctl_s1.seg_ovr  <= s_tdata[84];
			ctl_s1.b_en     <= 1'b0;
		end
	end

	// register file: one write port, two combinational read ports
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < x86ea_pkg::NUM_GPR; i++)
				gpr_q[i] <= '0;
		end else if (wr_go) begin
			gpr_q[idx_s1] <= val_s1;
		end
	end

	assign sel = x86ea_pkg::rd_select(ctl_s1.a32, ctl_s1.modrm, ctl_s1.tb[7:0]);
	assign opa = gpr_q[sel.a_idx];
	assign opb = gpr_q[sel.b_idx];

	always_comb begin
		agu_ctl      = ctl_s1;
		agu_ctl.b_en = sel.b_en;
	end

	x86ea_agu u_agu (
		.ctl (agu_ctl),
		.opa (opa),
		.opb (opb),
		.res (agu_res)
	);

	// stage 2
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (en2) begin
			valid_s2 <= valid_s1 && (op_s1 == x86ea_pkg::OP_EA);
		end
	end

	always_ff @(posedge clk) begin
		if (en2 && valid_s1 && (op_s1 == x86ea_pkg::OP_EA))
			res_s2 <= agu_res;
	end

	assign m_tvalid = valid_s2;
	assign m_tdata  = {4'd0, res_s2.len, res_s2.ss, res_s2.ea};
	assign m_tuser  = res_s2.is_reg;

endmodule

@@ tb/sv/tb_x86_modrm_effective_address.sv @@
// ----------------------------------------------------------------------------
// tb_x86_modrm_effective_address
// Self-checking bench for the ModR/M effective-address block: a directed table
// of corner cases, then random register writes and decodes under random and
// forced back-pressure, each result checked against a typed value or local predictor.
// ----------------------------------------------------------------------------
module tb_x86_modrm_effective_address;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int unsigned CYCLE_LIMIT = 500000;
	localparam int unsigned REPORT_CAP  = 100;
	localparam int unsigned CHUNK_ITEMS = 150;

	// one input transaction, field for field
	typedef struct packed {
		x86ea_pkg::op_t op;
		logic [2:0]     reg_index;
		logic [31:0]    reg_value;
		logic           address_32;
		logic [7:0]     modrm;
		logic [39:0]    trailing;
		logic           seg_override;
	} ea_request_t;

	// one output transaction
	typedef struct packed {
		logic [31:0] ea;
		logic        ss;
		logic        is_reg;
		logic [2:0]  len;
	} addr_result_t;

	// directed row: a result is typed in only where it is obvious
	typedef struct packed {
		ea_request_t  req;
		logic         fixed;
		addr_result_t result;
	} ea_row_t;

	logic        clk = 1'b0;
	logic        arst_n;
	logic        s_tvalid;
	logic        s_tready;
	logic [87:0] s_tdata;
	logic        s_tuser;
	logic        m_tvalid;
	logic        m_tready;
	logic [39:0] m_tdata;
	logic        m_tuser;

	// shadow of the general registers, updated at each accepted write
	logic [31:0]  gpr_shadow [x86ea_pkg::NUM_GPR];
	addr_result_t expected_addresses [$];
	ea_row_t      directed_table [$];

	int unsigned mismatch_count = 0;
	int unsigned cycle_count    = 0;
	bit          tx_idle_on     = 1'b1;
	bit          rx_idle_on     = 1'b1;
	int unsigned rx_hold_len    = 0;

	x86_modrm_effective_address u_top (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser)
	);

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	// watchdog
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("tb_x86_modrm_effective_address: FAIL");
			$finish;
		end
	end

	task automatic report_mismatch(input string what, input logic [31:0] got,
		input logic [31:0] want);
		mismatch_count++;
		if (mismatch_count <= REPORT_CAP)
			$display("ERROR %0t: %s got %0h want %0h", $time, what, got, want);
	endtask

	// Effective address, SS default, register flag and byte count for a decode,
	// formed from the shadow registers as they stand at acceptance.
	function automatic addr_result_t predict_address(input ea_request_t req);
		addr_result_t res;
		logic [1:0]   md;
		logic [2:0]   rm;
		logic [7:0]   sib;
		logic [2:0]   base;
		logic [2:0]   index;
		logic [1:0]   scale;
		logic [31:0]  addr;
		logic [39:0]  disp;
		int unsigned  byte_pos;
		res      = '0;
		md       = req.modrm[7:6];
		rm       = req.modrm[2:0];
		sib      = req.trailing[7:0];
		base     = sib[2:0];
		index    = sib[5:3];
		scale    = sib[7:6];
		addr     = '0;
		byte_pos = 0;
		if (md == x86ea_pkg::MOD_REG) begin
			res.is_reg = 1'b1;
			return res;
		end
		if (req.address_32) begin
			if (rm == x86ea_pkg::RM_SIB) begin
				byte_pos = 1;
				// SIB with base 5 and mod 0: disp32 stands in for the base
				if (md == x86ea_pkg::MOD_IND && base == x86ea_pkg::REG_EBP) begin
					addr     = req.trailing[39:8];
					byte_pos = 5;
				end else begin
					addr   = gpr_shadow[base];
					res.ss = (base == x86ea_pkg::REG_ESP || base == x86ea_pkg::REG_EBP);
				end
				// index 4 means no index; scale bits then don't matter
				if (index != x86ea_pkg::IDX_NONE)
					addr += gpr_shadow[index] << scale;
			end else if (md == x86ea_pkg::MOD_IND && rm == x86ea_pkg::RM_DISP) begin
				addr     = req.trailing[31:0];
				byte_pos = 4;
			end else begin
				addr   = gpr_shadow[rm];
				res.ss = (rm == x86ea_pkg::REG_EBP);
			end
			disp = req.trailing >> (8 * byte_pos);
			if (md == x86ea_pkg::MOD_D8) begin
				addr     += {{24{disp[7]}}, disp[7:0]};
				byte_pos += 1;
			end else if (md == x86ea_pkg::MOD_D32) begin
				addr     += disp[31:0];
				byte_pos += 4;
			end
			res.ea = addr;
		end else if (md == x86ea_pkg::MOD_IND && rm == x86ea_pkg::RM16_BP) begin
			// 16-bit direct: plain disp16, DS default
			res.ea   = {16'h0, req.trailing[15:0]};
			byte_pos = 2;
		end else begin
			case (rm)
				x86ea_pkg::RM16_BX_SI:
					addr = gpr_shadow[x86ea_pkg::REG_BX] + gpr_shadow[x86ea_pkg::REG_SI];
				x86ea_pkg::RM16_BX_DI:
					addr = gpr_shadow[x86ea_pkg::REG_BX] + gpr_shadow[x86ea_pkg::REG_DI];
				x86ea_pkg::RM16_BP_SI: begin
					addr   = gpr_shadow[x86ea_pkg::REG_BP] + gpr_shadow[x86ea_pkg::REG_SI];
					res.ss = 1'b1;
				end
				x86ea_pkg::RM16_BP_DI: begin
					addr   = gpr_shadow[x86ea_pkg::REG_BP] + gpr_shadow[x86ea_pkg::REG_DI];
					res.ss = 1'b1;
				end
				x86ea_pkg::RM16_SI: addr = gpr_shadow[x86ea_pkg::REG_SI];
				x86ea_pkg::RM16_DI: addr = gpr_shadow[x86ea_pkg::REG_DI];
				x86ea_pkg::RM16_BP: begin
					addr   = gpr_shadow[x86ea_pkg::REG_BP];
					res.ss = 1'b1;
				end
				default: addr = gpr_shadow[x86ea_pkg::REG_BX];
			endcase
			// mod 2 carries disp16 in 16-bit addressing
			if (md == x86ea_pkg::MOD_D8) begin
				addr     += {{24{req.trailing[7]}}, req.trailing[7:0]};
				byte_pos = 1;
			end else if (md == x86ea_pkg::MOD_D32) begin
				addr     += {16'h0, req.trailing[15:0]};
				byte_pos = 2;
			end
			res.ea = {16'h0, addr[15:0] & x86ea_pkg::ADDR16_MASK};
		end
		if (req.seg_override)
			res.ss = 1'b0;
		res.len = 3'(byte_pos);
		return res;
	endfunction

	function automatic ea_request_t decode_req(input logic a32, input logic [7:0] modrm,
		input logic [39:0] trailing, input logic ovr);
		ea_request_t req;
		req              = '0;
		req.op           = x86ea_pkg::OP_EA;
		req.address_32   = a32;
		req.modrm        = modrm;
		req.trailing     = trailing;
		req.seg_override = ovr;
		return req;
	endfunction

	function automatic ea_request_t write_req(input logic [2:0] idx, input logic [31:0] val);
		ea_request_t req;
		req           = '0;
		req.op        = x86ea_pkg::OP_REG_WR;
		req.reg_index = idx;
		req.reg_value = val;
		return req;
	endfunction

	// All fields random so every bit toggles; values lean toward the extremes
	// now and then to exercise wrap and sign extension.
	function automatic ea_request_t random_request();
		ea_request_t req;
		req.reg_index    = 3'($urandom_range(0, 7));
		req.address_32   = 1'($urandom_range(0, 1));
		req.modrm        = 8'($urandom_range(0, 255));
		req.trailing     = {8'($urandom), 32'($urandom)};
		req.seg_override = 1'($urandom_range(0, 1));
		case ($urandom_range(0, 5))
			0:       req.reg_value = 32'h0000_0000;
			1:       req.reg_value = 32'hFFFF_FFFF;
			2:       req.reg_value = 32'h8000_0000;
			3:       req.reg_value = 32'h7FFF_FFFF;
			default: req.reg_value = $urandom;
		endcase
		req.op = ($urandom_range(0, 99) < 20) ? x86ea_pkg::OP_REG_WR : x86ea_pkg::OP_EA;
		return req;
	endfunction

	// Drive one transaction from a falling edge and hold it until accepted.
	// Ends on the falling edge after acceptance. The shadow registers and the
	// expected queue are updated at the accepting edge.
	task automatic send_request(input ea_request_t req, input logic fixed,
		input addr_result_t fixed_res, input int unsigned gap);
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser  <= req.op;
		s_tdata  <= {3'b0, req.seg_override, req.trailing, req.modrm, req.address_32,
			req.reg_value, req.reg_index};
		do @(posedge clk); while (!s_tready);
		if (req.op == x86ea_pkg::OP_REG_WR)
			gpr_shadow[req.reg_index] = req.reg_value;
		else
			expected_addresses.push_back(fixed ? fixed_res : predict_address(req));
		@(negedge clk);
	endtask

	function automatic int unsigned tx_gap();
		return tx_idle_on ? $urandom_range(0, 12) : 0;
	endfunction

	task automatic run_random_chunk(input int unsigned count, input bit tx_idle,
		input bit rx_idle);
		tx_idle_on = tx_idle;
		rx_idle_on = rx_idle;
		repeat (count) send_request(random_request(), 1'b0, '0, tx_gap());
	endtask

	// sender goes idle, then waits for every outstanding result
	task automatic drain_results();
		s_tvalid <= 1'b0;
		while (expected_addresses.size() != 0) @(negedge clk);
	endtask

	// Receiver: a random stall before each result, and on request one long
	// hold so the pipeline fills and s_tready drops.
	initial begin
		int unsigned stall;
		m_tready = 1'b0;
		wait (arst_n === 1'b1);
		@(negedge clk);
		forever begin
			if (rx_hold_len > 0) begin
				m_tready <= 1'b0;
				repeat (rx_hold_len) @(negedge clk);
				rx_hold_len = 0;
			end
			stall = rx_idle_on ? $urandom_range(0, 12) : 0;
			if (stall > 0) begin
				m_tready <= 1'b0;
				repeat (stall) @(negedge clk);
			end
			m_tready <= 1'b1;
			do @(posedge clk); while (!m_tvalid && rx_hold_len == 0);
			@(negedge clk);
		end
	end

	// Result checker: every output transaction against the oldest expectation.
	always @(posedge clk) begin
		addr_result_t want;
		if (arst_n && m_tvalid && m_tready) begin
			if (expected_addresses.size() == 0) begin
				report_mismatch("result with nothing expected", m_tdata[31:0], '0);
			end else begin
				want = expected_addresses.pop_front();
				if (m_tdata[31:0] !== want.ea)
					report_mismatch("effective_address", m_tdata[31:0], want.ea);
				if (m_tdata[32] !== want.ss)
					report_mismatch("uses_stack_segment", 32'(m_tdata[32]), 32'(want.ss));
				if (m_tuser !== want.is_reg)
					report_mismatch("is_register_operand", 32'(m_tuser), 32'(want.is_reg));
				if (m_tdata[35:33] !== want.len)
					report_mismatch("bytes_after_modrm", 32'(m_tdata[35:33]), 32'(want.len));
			end
		end
	end

	initial begin
		arst_n   = 1'b0;
		s_tvalid = 1'b0;
		s_tdata  = '0;
		s_tuser  = 1'b0;
		foreach (gpr_shadow[i])
			gpr_shadow[i] = '0;

		// Directed rows. Registers are all zero right after reset, so the first
		// few results can be stated outright.
		directed_table.push_back(ea_row_t'{decode_req(1'b1, 8'h00, 40'h0, 1'b0), 1'b1,
			addr_result_t'{32'h0, 1'b0, 1'b0, 3'd0}});
		// register operands, the first with every other field at its top value
		directed_table.push_back(ea_row_t'{decode_req(1'b1, 8'hFF, 40'hFF_FFFF_FFFF, 1'b1),
			1'b1, addr_result_t'{32'h0, 1'b0, 1'b1, 3'd0}});
		directed_table.push_back(ea_row_t'{decode_req(1'b0, 8'hC0, 40'h0, 1'b0), 1'b1,
			addr_result_t'{32'h0, 1'b0, 1'b1, 3'd0}});
		// 32-bit disp32-only and 16-bit direct forms
		directed_table.push_back(ea_row_t'{decode_req(1'b1, 8'h05, 40'h00_FFFF_FFFF, 1'b0),
			1'b1, addr_result_t'{32'hFFFF_FFFF, 1'b0, 1'b0, 3'd4}});
		directed_table.push_back(ea_row_t'{decode_req(1'b0, 8'h3E, 40'hFF_FFFF_FFFF, 1'b0),
			1'b1, addr_result_t'{32'h0000_FFFF, 1'b0, 1'b0, 3'd2}});
		// load every register, extremes included
		directed_table.push_back(ea_row_t'{write_req(3'd0, 32'hFFFF_FFFF), 1'b0, '0});
		directed_table.push_back(ea_row_t'{write_req(3'd1, 32'h8000_0000), 1'b0, '0});
		directed_table.push_back(ea_row_t'{write_req(3'd2, 32'h7FFF_FFFF), 1'b0, '0});
		directed_table.push_back(ea_row_t'{write_req(3'd3, 32'h0000_FFFF), 1'b0, '0});
		directed_table.push_back(ea_row_t'{write_req(3'd4, 32'h1234_5678), 1'b0, '0});
		directed_table.push_back(ea_row_t'{write_req(3'd5, 32'hFFFF_FFFE), 1'b0, '0});
		directed_table.push_back(ea_row_t'{write_req(3'd6, 32'h0000_8001), 1'b0, '0});
		directed_table.push_back(ea_row_t'{write_req(3'd7, 32'hFFFF_0001), 1'b0, '0});
		// EBP + negative disp8, SS default; then the same under a segment prefix
		directed_table.push_back(ea_row_t'{decode_req(1'b1, 8'h45, 40'h80, 1'b0), 1'b0, '0});
		directed_table.push_back(ea_row_t'{decode_req(1'b1, 8'h45, 40'h80, 1'b1), 1'b0, '0});
		// SIB without base: disp32 + ECX*8
		directed_table.push_back(ea_row_t'{decode_req(1'b1, 8'h04, 40'hFF_FFFF_F0CD, 1'b0),
			1'b0, '0});
		// SIB base ESP, no index with scale bits set, disp8
		directed_table.push_back(ea_row_t'{decode_req(1'b1, 8'h44, 40'h7FE4, 1'b0), 1'b0, '0});
		// SIB base EBP + EDI*2 + disp32
		directed_table.push_back(ea_row_t'{decode_req(1'b1, 8'h84, 40'h80_0000_017D, 1'b0),
			1'b0, '0});
		// EDX + disp32 wrapping past 2^32
		directed_table.push_back(ea_row_t'{decode_req(1'b1, 8'h82, 40'hFF_FFFF_FFFF, 1'b0),
			1'b0, '0});
		// 16-bit: BX+SI wrapping, BP+DI+disp16, BP+SI+disp8 with prefix,
		// BP+disp16, SI+disp8, DI+disp16, BX
		directed_table.push_back(ea_row_t'{decode_req(1'b0, 8'h00, 40'h0, 1'b0), 1'b0, '0});
		directed_table.push_back(ea_row_t'{decode_req(1'b0, 8'h83, 40'h7FFF, 1'b0), 1'b0, '0});
		directed_table.push_back(ea_row_t'{decode_req(1'b0, 8'h42, 40'hFF, 1'b1), 1'b0, '0});
		directed_table.push_back(ea_row_t'{decode_req(1'b0, 8'h86, 40'hFFFF, 1'b0), 1'b0, '0});
		directed_table.push_back(ea_row_t'{decode_req(1'b0, 8'h44, 40'h7F, 1'b0), 1'b0, '0});
		directed_table.push_back(ea_row_t'{decode_req(1'b0, 8'hBD, 40'h8000, 1'b0), 1'b0, '0});
		directed_table.push_back(ea_row_t'{decode_req(1'b0, 8'h07, 40'h0, 1'b0), 1'b0, '0});

		repeat (7) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		foreach (directed_table[i])
			send_request(directed_table[i].req, directed_table[i].fixed,
				directed_table[i].result, tx_gap());
		// sender pause: let every directed result come back first
		drain_results();

		run_random_chunk(CHUNK_ITEMS, 1'b1, 1'b1);
		run_random_chunk(CHUNK_ITEMS, 1'b0, 1'b0);

		// Long receiver hold while the sender streams back to back: the
		// pipeline fills and the input stalls.
		rx_hold_len = 80;
		run_random_chunk(40, 1'b0, 1'b0);
		drain_results();

		run_random_chunk(CHUNK_ITEMS, 1'b1, 1'b0);
		run_random_chunk(CHUNK_ITEMS, 1'b0, 1'b1);
		run_random_chunk(CHUNK_ITEMS, 1'b1, 1'b1);
		drain_results();
		run_random_chunk(CHUNK_ITEMS, 1'b0, 1'b0);
		run_random_chunk(CHUNK_ITEMS, 1'b1, 1'b1);
		rx_hold_len = 60;
		run_random_chunk(CHUNK_ITEMS, 1'b0, 1'b0);
		run_random_chunk(CHUNK_ITEMS, 1'b1, 1'b0);
		run_random_chunk(CHUNK_ITEMS, 1'b0, 1'b1);
		run_random_chunk(CHUNK_ITEMS, 1'b0, 1'b0);
		run_random_chunk(CHUNK_ITEMS, 1'b1, 1'b1);

		drain_results();
		// wait here so any stray result is caught
		repeat (8) @(posedge clk);

		if (expected_addresses.size() != 0)
			report_mismatch("results never seen", expected_addresses.size(), 0);
		if (mismatch_count == 0) begin
			$display("tb_x86_modrm_effective_address: PASS");
		end else begin
			$display("tb_x86_modrm_effective_address: FAIL");
		end
		$finish;
	end

endmodule

@@ files.f @@
rtl/x86ea_pkg.sv
rtl/x86ea_agu.sv
rtl/x86_modrm_effective_address.sv
tb/sv/tb_x86_modrm_effective_address.sv
